// ----- hw/rtl/point_to_line_projection_top_assert.svh -----
// Assertion macros shared by the projection block.
`ifndef POINT_TO_LINE_PROJECTION_TOP_ASSERT_SVH
`define POINT_TO_LINE_PROJECTION_TOP_ASSERT_SVH

// Check that c holds in the same cycle as a.
`define PLTP_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pltp assertion failed");

// Check that c holds in the cycle after a.
`define PLTP_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pltp assertion failed");

`endif

// ----- hw/rtl/pltp_pkg.sv -----
package pltp_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_DEGEN   = 2'd0;
  localparam status_t ST_WITHIN  = 2'd1;
  localparam status_t ST_OUTSIDE = 2'd2;

endpackage

// ----- hw/rtl/pltp_div_cell.sv -----
module pltp_div_cell #(
  parameter int SQW = 34,
  parameter int QB  = 50
) (
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] rem_i,
  input  logic [QB-1:0]  dvd_i,
  input  logic [SQW-1:0] den_i,
  input  logic [QB-1:0]  q_i,
  output logic [SQW-1:0] rem_o,
  output logic [QB-1:0]  dvd_o,
  output logic [SQW-1:0] den_o,
  output logic [QB-1:0]  q_o
);

  logic [SQW:0] r2;
  logic [SQW:0] diff;
  logic         ge;

  // Shift in the next dividend bit, subtract the divisor where it fits.
  assign r2   = {rem_i, dvd_i[QB-1]};
  assign diff = r2 - {1'b0, den_i};
  assign ge   = (r2 >= {1'b0, den_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[SQW-1:0] : r2[SQW-1:0];
      dvd_o <= {dvd_i[QB-2:0], 1'b0};
      den_o <= den_i;
      q_o   <= {q_i[QB-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/pltp_sqrt_cell.sv -----
module pltp_sqrt_cell #(
  parameter int DB = 25
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DB:0]     rem_i,
  input  logic [DB-1:0]   root_i,
  input  logic [2*DB-1:0] rad_i,
  output logic [DB:0]     rem_o,
  output logic [DB-1:0]   root_o,
  output logic [2*DB-1:0] rad_o
);

  logic [DB+2:0] r2;
  logic [DB+2:0] trial;
  logic [DB+2:0] diff;
  logic          ge;

  // Bring down two radicand bits and try root bit one.
  assign r2    = {rem_i, rad_i[2*DB-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = r2 - trial;
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[DB:0] : r2[DB:0];
      root_o <= {root_i[DB-2:0], ge};
      rad_o  <= {rad_i[2*DB-3:0], 2'b00};
    end
  end

endmodule

// ----- hw/rtl/point_to_line_projection_top.sv -----
// Point-to-line projection. Each transfer on s carries line points A, B and a
// query point P; each transfer on m returns the perpendicular foot (truncated
// toward zero), the distance in fixed point with FRAC_BITS fraction bits
// (floored) and a status in tuser: degenerate line, foot within the segment,
// or foot outside. One item is taken every cycle unless a result waits at m;
// each item passes through the chain of restoring divide cells, one quotient
// bit per cell, then the square-root cells, one root bit per cell (50 divide
// cells per lane, 25 root cells and 6 set-up, dot and output stages at the
// defaults). The whole chain advances together and holds when a result waits
// at m. No state survives between items; reset clears valids.
module point_to_line_projection_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // lowest bit up: line_a_x, line_a_y, line_b_x, line_b_y, query_x, query_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // lowest bit up: foot_x, foot_y, dist_q8
  output logic [((2*(COORD_BITS+2)+COORD_BITS+FRAC_BITS+1+7)/8)*8-1:0] m_tdata,
  // lowest bit up: status
  output pltp_pkg::status_t m_tuser
);

  import pltp_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int D   = C + 1;            // coordinate difference
  localparam int SQW = 2 * C + 2;        // squared length, |num|
  localparam int H   = SQW / 2;          // half split for wide products
  localparam int DB  = C + FRAC_BITS + 1;
  localparam int QB  = 2 * DB;           // quotient bits of every divider
  localparam int XW  = 3 * C + 4;        // foot numerators
  localparam int FW  = C + 2;
  localparam int MW  = QB + SQW;         // scaled squared numerator
  localparam int SW  = 3 + 4 * C;        // side payload through dividers
  localparam int TW  = 1 + 2 * FW + 4 * C;
  localparam int OW  = ((2 * FW + DB + 7) / 8) * 8;

  logic en;

  // The chain moves as one; a waiting result stalls it.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: differences and small products
  logic signed [C-1:0] in_ax, in_ay, in_bx, in_by, in_px, in_py;
  logic signed [D-1:0] dx_c, dy_c, ux_c, uy_c;

  assign in_ax = s_tdata[C-1:0];
  assign in_ay = s_tdata[2*C-1:C];
  assign in_bx = s_tdata[3*C-1:2*C];
  assign in_by = s_tdata[4*C-1:3*C];
  assign in_px = s_tdata[5*C-1:4*C];
  assign in_py = s_tdata[6*C-1:5*C];
  assign dx_c  = $signed({in_bx[C-1], in_bx}) - $signed({in_ax[C-1], in_ax});
  assign dy_c  = $signed({in_by[C-1], in_by}) - $signed({in_ay[C-1], in_ay});
  assign ux_c  = $signed({in_px[C-1], in_px}) - $signed({in_ax[C-1], in_ax});
  assign uy_c  = $signed({in_py[C-1], in_py}) - $signed({in_ay[C-1], in_ay});

  logic                  v1;
  logic signed [2*D-1:0] s1_dyux, s1_dxuy, s1_dxdx, s1_dydy;
  logic signed [D-1:0]   s1_dx, s1_dy;
  logic signed [C-1:0]   s1_px, s1_py;
  logic [4*C-1:0]        s1_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dyux <= dy_c * ux_c;
      s1_dxuy <= dx_c * uy_c;
      s1_dxdx <= dx_c * dx_c;
      s1_dydy <= dy_c * dy_c;
      s1_dx   <= dx_c;
      s1_dy   <= dy_c;
      s1_px   <= in_px;
      s1_py   <= in_py;
      s1_ab   <= {in_ax, in_ay, in_bx, in_by};
    end
  end

  // ---------------- stage 2: squared length and cross product
  logic                v2;
  logic [SQW-1:0]      s2_sq;
  logic signed [SQW:0] s2_num;
  logic signed [D-1:0] s2_dx, s2_dy;
  logic signed [C-1:0] s2_px, s2_py;
  logic [4*C-1:0]      s2_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq  <= SQW'(unsigned'(s1_dxdx)) + SQW'(unsigned'(s1_dydy));
      s2_num <= $signed({s1_dyux[2*D-1], s1_dyux}) - $signed({s1_dxuy[2*D-1], s1_dxuy});
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_px  <= s1_px;
      s2_py  <= s1_py;
      s2_ab  <= s1_ab;
    end
  end

  // ---------------- stage 3: partial products of the wide terms
  logic [SQW:0]   nabs_c;
  logic [SQW-1:0] n_c;
  logic [H-1:0]   nlo_c, nhi_c, slo_c, shi_c, nslo_c;
  logic [H:0]     nshi_c;

  assign nabs_c = s2_num[SQW] ? -s2_num : s2_num;
  assign n_c    = nabs_c[SQW-1:0];
  assign nlo_c  = n_c[H-1:0];
  assign nhi_c  = n_c[SQW-1:H];
  assign slo_c  = s2_sq[H-1:0];
  assign shi_c  = s2_sq[SQW-1:H];
  assign nslo_c = s2_num[H-1:0];
  assign nshi_c = s2_num[SQW:H];

  logic                    v3;
  logic [2*H-1:0]          s3_nll, s3_nlh, s3_nhh;
  logic signed [C+H:0]     s3_pxl, s3_pxh, s3_pyl, s3_pyh;
  logic signed [D+H:0]     s3_dyl, s3_dxl;
  logic signed [D+H:0]     s3_dyh, s3_dxh;
  logic [SQW-1:0]          s3_sq;
  logic [4*C-1:0]          s3_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nll <= nlo_c * nlo_c;
      s3_nlh <= nlo_c * nhi_c;
      s3_nhh <= nhi_c * nhi_c;
      s3_pxl <= s2_px * $signed({1'b0, slo_c});
      s3_pxh <= s2_px * $signed({1'b0, shi_c});
      s3_pyl <= s2_py * $signed({1'b0, slo_c});
      s3_pyh <= s2_py * $signed({1'b0, shi_c});
      s3_dyl <= s2_dy * $signed({1'b0, nslo_c});
      s3_dxl <= s2_dx * $signed({1'b0, nslo_c});
      s3_dyh <= (D+H+1)'(s2_dy * $signed(nshi_c));
      s3_dxh <= (D+H+1)'(s2_dx * $signed(nshi_c));
      s3_sq  <= s2_sq;
      s3_ab  <= s2_ab;
    end
  end

  // ---------------- stage 4: sum wide terms, split into magnitude and sign
  logic [MW-1:0]      nsq_c;
  logic signed [XW-1:0] xn_c, yn_c;

  assign nsq_c = ((MW'(s3_nhh) << SQW) + (MW'(s3_nlh) << (H + 1)) + MW'(s3_nll))
                 << (2 * FRAC_BITS);
  assign xn_c  = (XW'(s3_pxh) <<< H) + XW'(s3_pxl) - (XW'(s3_dyh) <<< H) - XW'(s3_dyl);
  assign yn_c  = (XW'(s3_pyh) <<< H) + XW'(s3_pyl) + (XW'(s3_dxh) <<< H) + XW'(s3_dxl);

  logic            v4;
  logic [MW-1:0]   s4_nsq;
  logic [XW-1:0]   s4_xmag, s4_ymag;
  logic            s4_xneg, s4_yneg, s4_deg;
  logic [SQW-1:0]  s4_sq;
  logic [4*C-1:0]  s4_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nsq  <= nsq_c;
      s4_xneg <= xn_c[XW-1];
      s4_yneg <= yn_c[XW-1];
      s4_xmag <= xn_c[XW-1] ? unsigned'(-xn_c) : unsigned'(xn_c);
      s4_ymag <= yn_c[XW-1] ? unsigned'(-yn_c) : unsigned'(yn_c);
      s4_deg  <= (s3_sq == '0);
      s4_sq   <= s3_sq;
      s4_ab   <= s3_ab;
    end
  end

  // ---------------- divider chain: one quotient bit per cell, three lanes
  logic [MW-1:0] xext, yext;
  assign xext = MW'(s4_xmag);
  assign yext = MW'(s4_ymag);

  logic [SQW-1:0] dr [0:QB];
  logic [QB-1:0]  dd [0:QB];
  logic [SQW-1:0] dn [0:QB];
  logic [QB-1:0]  dq [0:QB];
  logic [SQW-1:0] xr [0:QB];
  logic [QB-1:0]  xd [0:QB];
  logic [SQW-1:0] xs [0:QB];
  logic [QB-1:0]  xq [0:QB];
  logic [SQW-1:0] yr [0:QB];
  logic [QB-1:0]  yd [0:QB];
  logic [SQW-1:0] ys [0:QB];
  logic [QB-1:0]  yq [0:QB];
  logic [SW-1:0]  side [0:QB];
  logic           dv   [0:QB];

  // High part of each dividend seeds the remainder; it is below the divisor.
  assign dr[0]   = s4_nsq[MW-1:QB];
  assign dd[0]   = s4_nsq[QB-1:0];
  assign dn[0]   = s4_sq;
  assign dq[0]   = '0;
  assign xr[0]   = xext[MW-1:QB];
  assign xd[0]   = xext[QB-1:0];
  assign xs[0]   = s4_sq;
  assign xq[0]   = '0;
  assign yr[0]   = yext[MW-1:QB];
  assign yd[0]   = yext[QB-1:0];
  assign ys[0]   = s4_sq;
  assign yq[0]   = '0;
  assign side[0] = {s4_deg, s4_xneg, s4_yneg, s4_ab};
  assign dv[0]   = v4;

  for (genvar k = 0; k < QB; k++) begin : g_div
    pltp_div_cell #(.SQW(SQW), .QB(QB)) u_dist (
      .clk(clk), .en(en),
      .rem_i(dr[k]), .dvd_i(dd[k]), .den_i(dn[k]), .q_i(dq[k]),
      .rem_o(dr[k+1]), .dvd_o(dd[k+1]), .den_o(dn[k+1]), .q_o(dq[k+1])
    );
    pltp_div_cell #(.SQW(SQW), .QB(QB)) u_fx (
      .clk(clk), .en(en),
      .rem_i(xr[k]), .dvd_i(xd[k]), .den_i(xs[k]), .q_i(xq[k]),
      .rem_o(xr[k+1]), .dvd_o(xd[k+1]), .den_o(xs[k+1]), .q_o(xq[k+1])
    );
    pltp_div_cell #(.SQW(SQW), .QB(QB)) u_fy (
      .clk(clk), .en(en),
      .rem_i(yr[k]), .dvd_i(yd[k]), .den_i(ys[k]), .q_i(yq[k]),
      .rem_o(yr[k+1]), .dvd_o(yd[k+1]), .den_o(ys[k+1]), .q_o(yq[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
      end
    end
  end

  // ---------------- square-root chain: one root bit per cell
  logic [FW-1:0] fxq, fyq;
  logic [FW-1:0] fx_c, fy_c;
  logic          xneg_q, yneg_q, deg_q;

  assign deg_q  = side[QB][SW-1];
  assign xneg_q = side[QB][SW-2];
  assign yneg_q = side[QB][SW-3];
  assign fxq    = xq[QB][FW-1:0];
  assign fyq    = yq[QB][FW-1:0];
  // Apply the sign to the truncated magnitude: truncation toward zero.
  assign fx_c   = xneg_q ? -fxq : fxq;
  assign fy_c   = yneg_q ? -fyq : fyq;

  logic [DB:0]     sr [0:DB];
  logic [DB-1:0]   st [0:DB];
  logic [QB-1:0]   sd [0:DB];
  logic [TW-1:0]   tail [0:DB];
  logic            sv   [0:DB];

  assign sr[0]   = '0;
  assign st[0]   = '0;
  assign sd[0]   = dq[QB];
  assign tail[0] = {deg_q, fx_c, fy_c, side[QB][4*C-1:0]};
  assign sv[0]   = dv[QB];

  for (genvar j = 0; j < DB; j++) begin : g_sqrt
    pltp_sqrt_cell #(.DB(DB)) u_cell (
      .clk(clk), .en(en),
      .rem_i(sr[j]), .root_i(st[j]), .rad_i(sd[j]),
      .rem_o(sr[j+1]), .root_o(st[j+1]), .rad_o(sd[j+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tail[j+1] <= tail[j];
      end
    end
  end

  // ---------------- dot stage: products of foot-to-end offsets
  logic signed [FW-1:0] tfx, tfy;
  logic signed [C-1:0]  tax, tay, tbx, tby;
  logic                 tdeg;
  logic signed [FW:0]   ea_x, eb_x, ea_y, eb_y;

  assign tdeg = tail[DB][TW-1];
  assign tfx  = tail[DB][TW-2 -: FW];
  assign tfy  = tail[DB][TW-2-FW -: FW];
  assign tax  = tail[DB][4*C-1:3*C];
  assign tay  = tail[DB][3*C-1:2*C];
  assign tbx  = tail[DB][2*C-1:C];
  assign tby  = tail[DB][C-1:0];
  assign ea_x = (FW+1)'(tfx) - (FW+1)'(tax);
  assign eb_x = (FW+1)'(tfx) - (FW+1)'(tbx);
  assign ea_y = (FW+1)'(tfy) - (FW+1)'(tay);
  assign eb_y = (FW+1)'(tfy) - (FW+1)'(tby);

  logic                    v5;
  logic signed [2*FW+1:0]  s5_px, s5_py;
  logic [FW-1:0]           s5_fx, s5_fy;
  logic [DB-1:0]           s5_dist;
  logic                    s5_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sv[DB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_px   <= ea_x * eb_x;
      s5_py   <= ea_y * eb_y;
      s5_fx   <= tfx;
      s5_fy   <= tfy;
      s5_dist <= st[DB];
      s5_deg  <= tdeg;
    end
  end

  // ---------------- output register: dot sign, degenerate override
  logic signed [2*FW+2:0] dot_c;
  status_t                st_c;

  assign dot_c = (2*FW+3)'(s5_px) + (2*FW+3)'(s5_py);

  always_comb begin
    if (s5_deg) begin
      st_c = ST_DEGEN;
    end else if (dot_c[2*FW+2] || dot_c == '0) begin
      st_c = ST_WITHIN;
    end else begin
      st_c = ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= st_c;
      if (s5_deg) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= OW'({s5_dist, s5_fy, s5_fx});
      end
    end
  end

`include "point_to_line_projection_top_assert.svh"

  `PLTP_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser == ST_DEGEN, m_tdata == '0)
  `PLTP_ASSERT_NOW(a_status_code, m_tvalid, m_tuser == ST_DEGEN || m_tuser == ST_WITHIN || m_tuser == ST_OUTSIDE)
  `PLTP_ASSERT_NOW(a_empty_takes, !m_tvalid, s_tready)

endmodule

// ----- tb/tb_point_to_line_projection_top.sv -----
`timescale 1ns / 1ps

module tb_point_to_line_projection_top;
  import pltp_pkg::*;

  localparam int CW = 16;
  localparam int FW = 8;
  localparam int FOOT_W = CW + 2;
  localparam int DIST_W = CW + FW + 1;
  localparam int SW = ((6 * CW + 7) / 8) * 8;
  localparam int MW = ((2 * FOOT_W + DIST_W + 7) / 8) * 8;
  localparam int N_RANDOM = 450;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [CW-1:0] qy, qx, by, bx, ay, ax;
  } query_t;

  typedef struct packed {
    logic [FOOT_W-1:0] foot_x;
    logic [FOOT_W-1:0] foot_y;
    logic [DIST_W-1:0] dist_q8;
    status_t           status;
  } projection_t;

  // One row of the directed table; known marks a hand-typed expectation.
  typedef struct {
    query_t      q;
    bit          known;
    projection_t res;
  } directed_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [SW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [MW-1:0] m_tdata;
  status_t m_tuser;

  projection_t expected_q[$];
  int mismatches;
  int stall_cycles;
  bit timed_out;
  bit send_done;

  point_to_line_projection_top #(.COORD_BITS(CW), .FRAC_BITS(FW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Signed truncating divide on exact integers.
  function automatic longint div_trunc(longint n, longint d);
    longint q;
    q = (n < 0 ? -n : n) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Project P onto line AB in exact integer arithmetic.
  function automatic projection_t project_point(query_t q);
    projection_t r;
    longint ax, ay, bx, by, px, py, dx, dy, sq, num, fx, fy, dot;
    logic [127:0] rhs, lhs, cand, mag, root;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; px = q.qx; py = q.qy;
    dx = bx - ax;
    dy = by - ay;
    sq = dx * dx + dy * dy;
    if (sq == 0) begin
      r.foot_x = '0; r.foot_y = '0; r.dist_q8 = '0; r.status = ST_DEGEN;
      return r;
    end
    num = dy * (px - ax) - dx * (py - ay);
    mag = (num < 0) ? -num : num;
    rhs = (mag * mag) << (2 * FW);
    root = '0;
    // Build the root one bit at a time: largest d with d*d*sq <= rhs.
    for (int b = DIST_W; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      lhs = cand * cand * sq;
      if (lhs <= rhs) root = cand;
    end
    fx = div_trunc(px * sq - dy * num, sq);
    fy = div_trunc(py * sq + dx * num, sq);
    dot = (fx - ax) * (fx - bx) + (fy - ay) * (fy - by);
    r.foot_x = fx[FOOT_W-1:0];
    r.foot_y = fy[FOOT_W-1:0];
    r.dist_q8 = root[DIST_W-1:0];
    r.status = (dot <= 0) ? ST_WITHIN : ST_OUTSIDE;
    return r;
  endfunction

  function automatic query_t make_query(int ax, int ay, int bx, int by, int px, int py);
    query_t q;
    q.ax = CW'(ax); q.ay = CW'(ay); q.bx = CW'(bx); q.by = CW'(by);
    q.qx = CW'(px); q.qy = CW'(py);
    return q;
  endfunction

  // Random coordinate: mostly full range, sometimes extremes or near zero.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // Make some lines degenerate and put some queries on an end point.
    if ($urandom_range(0, 15) == 0) begin
      q.bx = q.ax; q.by = q.ay;
    end else if ($urandom_range(0, 15) == 0) begin
      q.qx = q.ax; q.qy = q.ay;
    end
    return q;
  endfunction

  // Push one item through s, with a random gap before it.
  task automatic send_item(query_t q, projection_t res);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= SW'(q);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_q.insert(expected_q.size(), res);
    @(negedge clk);
  endtask

  directed_row_t rows[$];
  projection_t zero_res;

  // Append one row to the directed table.
  task automatic add_row(query_t q, bit known, projection_t res);
    rows.insert(rows.size(), '{q, known, res});
  endtask

  // Stimulus
  initial begin
    query_t q;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_done = 1'b0;
    zero_res = '{default: '0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Degenerate lines: all zero fields.
    add_row(make_query(0, 0, 0, 0, 0, 0), 1, zero_res);
    add_row(make_query(32767, -32768, 32767, -32768, -32768, 32767), 1, zero_res);
    add_row(make_query(-32768, -32768, -32768, -32768, 5, 5), 1, zero_res);
    // Query on end point A: foot at A, distance zero, within.
    add_row(make_query(3, 4, 10, 4, 3, 4), 1,
            '{18'd3, 18'd4, 25'd0, ST_WITHIN});
    // Horizontal line, query above: foot (5,0), distance 7.0.
    add_row(make_query(0, 0, 10, 0, 5, 7), 1,
            '{18'd5, 18'd0, 25'd1792, ST_WITHIN});
    // Foot beyond B.
    add_row(make_query(0, 0, 10, 0, 20, -3), 1,
            '{18'd20, 18'd0, 25'd768, ST_OUTSIDE});
    add_row(make_query(-32768, -32768, 32767, 32767, -32768, 32767), 0, zero_res);
    add_row(make_query(-32768, 32767, 32767, -32768, 32767, 32767), 0, zero_res);
    add_row(make_query(-32768, -32768, 32767, -32767, 32767, 32767), 0, zero_res);
    add_row(make_query(32767, 32767, -32768, -32768, -32768, -32768), 0, zero_res);
    add_row(make_query(0, 0, 1, 0, -32768, 32767), 0, zero_res);
    add_row(make_query(0, 0, 1, 1, 32767, -32768), 0, zero_res);
    add_row(make_query(-5, -5, 5, 5, 0, 1), 0, zero_res);
    add_row(make_query(0, 0, 3, 7, -2, 9), 0, zero_res);
    add_row(make_query(1, 2, 1, 3, -32768, -32768), 0, zero_res);
    add_row(make_query(-1, -1, 0, 0, 1, 1), 0, zero_res);

    foreach (rows[i])
      send_item(rows[i].q, rows[i].known ? rows[i].res : project_point(rows[i].q));
    for (int i = 0; i < N_RANDOM; i++) begin
      q = rand_query();
      send_item(q, project_point(q));
    end
    s_tvalid <= 1'b0;
    send_done = 1'b1;
  end

  // Result side: random back-pressure, compare in order.
  initial begin
    projection_t got, exp_res;
    int gap;
    m_tready = 1'b0;
    mismatches = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.foot_x  = m_tdata[FOOT_W-1:0];
      got.foot_y  = m_tdata[2*FOOT_W-1:FOOT_W];
      got.dist_q8 = m_tdata[2*FOOT_W+DIST_W-1:2*FOOT_W];
      got.status  = m_tuser;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer on m: %p", got);
      end else begin
        exp_res = expected_q.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_res, got);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  initial begin
    stall_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
  end

  // End of run
  initial begin
    wait (send_done || timed_out);
    while (expected_q.size() != 0 && !timed_out) @(posedge clk);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (timed_out || mismatches != 0 || expected_q.size() != 0) begin
      $display("tb_point_to_line_projection_top failed");
    end else begin
      $display("tb_point_to_line_projection_top passed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pltp_pkg.sv
hw/rtl/pltp_div_cell.sv
hw/rtl/pltp_sqrt_cell.sv
hw/rtl/point_to_line_projection_top.sv
tb/tb_point_to_line_projection_top.sv
